### src/dbrle_pkg.sv
// shared types and constants for the doubled byte run-length encoder
// no dependencies; imported by dbrle_core, dbrle_outq and the top level
package dbrle_pkg;

  // a run closes once it has counted this many extra repeats
  localparam logic [7:0] MAX_EXTRA = 8'd255;

  // output queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  // results of one input word: up to two output words
  typedef struct packed {
    logic [1:0] num;
    word_t      w0;
    word_t      w1;
  } step_res_t;

endpackage

### src/dbrle_core.sv
// encoder state and the per-word encoding decision
// depends on dbrle_pkg
module dbrle_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic                is_last,
  output dbrle_pkg::step_res_t res
);
  import dbrle_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] held_byte, held_byte_next;
  logic [7:0] extra_count, extra_count_next;
  logic [8:0] extra_inc;
  logic       match;

  assign extra_inc = {1'b0, extra_count} + 9'd1;
  assign match     = (data_byte == held_byte) && !is_last;

  always_comb begin
    res              = '0;
    phase_next       = phase;
    held_byte_next   = held_byte;
    extra_count_next = extra_count;
    case (phase)
      PH_ONE: begin
        res.num = 2'd1;
        res.w0  = '{data: data_byte, last: is_last};
        if (match) begin
          phase_next       = PH_RUN;
          extra_count_next = 8'd0;
        end else begin
          held_byte_next = data_byte;
          phase_next     = is_last ? PH_IDLE : PH_ONE;
        end
      end
      PH_RUN: begin
        if (match) begin
          if (extra_inc >= {1'b0, MAX_EXTRA}) begin
            // full run: send the count now and start fresh
            res.num          = 2'd1;
            res.w0           = '{data: MAX_EXTRA, last: 1'b0};
            phase_next       = PH_IDLE;
            extra_count_next = 8'd0;
          end else begin
            extra_count_next = extra_inc[7:0];
          end
        end else begin
          res.num          = 2'd2;
          res.w0           = '{data: extra_count, last: 1'b0};
          res.w1           = '{data: data_byte, last: is_last};
          extra_count_next = 8'd0;
          held_byte_next   = data_byte;
          phase_next       = is_last ? PH_IDLE : PH_ONE;
        end
      end
      default: begin
        res.num          = 2'd1;
        res.w0           = '{data: data_byte, last: is_last};
        held_byte_next   = data_byte;
        extra_count_next = 8'd0;
        phase_next       = is_last ? PH_IDLE : PH_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      held_byte   <= 8'd0;
      extra_count <= 8'd0;
    end else if (in_fire) begin
      phase       <= phase_next;
      held_byte   <= held_byte_next;
      extra_count <= extra_count_next;
    end
  end

endmodule

### src/dbrle_outq.sv
// small output queue taking zero to two words per cycle, one out per cycle while pop is high
// depends on dbrle_pkg
module dbrle_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dbrle_pkg::step_res_t res,
  input  logic                 pop,
  output logic                 room,
  output logic                 not_empty,
  output dbrle_pkg::word_t     head_word
);
  import dbrle_pkg::*;

  word_t               mem [QDEPTH];
  logic [QPTR_W-1:0]   head, tail;
  logic [QCNT_W-1:0]   count;
  logic [1:0]          num;

  assign num       = push ? res.num : 2'd0;
  assign not_empty = (count != '0);
  // room for the worst case of two words
  assign room      = (count <= QCNT_W'(QDEPTH - 2));
  assign head_word = mem[head];

  always_ff @(posedge clk) begin
    if (num != 2'd0) mem[tail] <= res.w0;
    if (num == 2'd2) mem[tail + QPTR_W'(1)] <= res.w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QPTR_W'(num);
      if (pop) head <= head + QPTR_W'(1);
      count <= count + QCNT_W'(num) - QCNT_W'(pop);
    end
  end

endmodule

### src/doubled_byte_run_length_encoder.sv
// a word's results are written into the output queue when it is accepted and leave it in order
// throughput: one input word per cycle while the queue has room; a closed run yields two
// output words, and the fill of the four-entry output queue sets when input stalls
// reset: synchronous rst clears the encoder phase, held byte, count and queue
// depends on dbrle_pkg, dbrle_core, dbrle_outq
module doubled_byte_run_length_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import dbrle_pkg::*;

  step_res_t res;
  word_t     head_word;
  logic      in_fire;
  logic      room;

  assign in_ready = room;
  assign in_fire  = in_valid && room;

  dbrle_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .is_last   (is_last),
    .res       (res)
  );

  dbrle_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .res       (res),
    .pop       (out_valid && out_ready),
    .room      (room),
    .not_empty (out_valid),
    .head_word (head_word)
  );

  assign out_byte = head_word.data;
  assign out_last = head_word.last;

endmodule

### src/dbrle_chk.sv
// port-level checks for the doubled byte run-length encoder
// no package dependency; bound to the top level below
module dbrle_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] data_byte,
  input logic       is_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  // the end of a stream always produces a word
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_last |=> out_valid)
    else $error("no output after final input word");

  // an empty output side never blocks input
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with nothing pending");

  // output appears only after an accepted input
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(out_valid) && !$past(in_valid && in_ready) |-> !out_valid)
    else $error("output word without input");

endmodule

bind doubled_byte_run_length_encoder dbrle_chk u_dbrle_chk (.*);

### tb/rle_stream_checker.sv
`timescale 1ns / 100ps
// watches both channels of the run-length encoder, predicts the encoded words
// and compares them in order; depends on dbrle_pkg
module rle_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         mismatches,
  output int         backlog
);
  import dbrle_pkg::*;

  phase_t     enc_phase;
  logic [7:0] enc_held;
  logic [7:0] enc_extra;
  word_t      encoded_words[$];
  word_t      oldest;

  function automatic void queue_word(input logic [7:0] b, input logic l);
    word_t w;
    w.data = b;
    w.last = l;
    encoded_words.push_back(w);
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic l);
    case (enc_phase)
      PH_ONE: begin
        queue_word(b, l);
        if (b == enc_held && !l) begin
          enc_phase = PH_RUN;
          enc_extra = '0;
        end else begin
          enc_held  = b;
          enc_phase = l ? PH_IDLE : PH_ONE;
        end
      end
      PH_RUN: begin
        if (b == enc_held && !l) begin
          // a full run closes at once and the next byte starts fresh
          if (enc_extra + 9'd1 >= MAX_EXTRA) begin
            queue_word(MAX_EXTRA, 1'b0);
            enc_phase = PH_IDLE;
            enc_extra = '0;
          end else begin
            enc_extra = enc_extra + 8'd1;
          end
        end else begin
          // count first, then the byte that broke the run
          queue_word(enc_extra, 1'b0);
          queue_word(b, l);
          enc_extra = '0;
          enc_held  = b;
          enc_phase = l ? PH_IDLE : PH_ONE;
        end
      end
      default: begin
        queue_word(b, l);
        enc_held  = b;
        enc_extra = '0;
        enc_phase = l ? PH_IDLE : PH_ONE;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      enc_phase = PH_IDLE;
      enc_held  = '0;
      enc_extra = '0;
      encoded_words.delete();
      mismatches <= 0;
      backlog    <= 0;
    end else begin
      if (in_valid && in_ready) begin
        encode_byte(data_byte, is_last);
      end
      if (out_valid && out_ready) begin
        if (encoded_words.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected output word at %0t: byte %02h last %0b",
                     $time, out_byte, out_last);
          end
          mismatches <= mismatches + 1;
        end else begin
          oldest = encoded_words.pop_front();
          if (oldest.data !== out_byte || oldest.last !== out_last) begin
            if (mismatches < 10) begin
              $display("mismatch at %0t: expected byte %02h last %0b, got byte %02h last %0b",
                       $time, oldest.data, oldest.last, out_byte, out_last);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      backlog <= encoded_words.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// top of the run-length encoder testbench: clock, reset, byte streams, output
// back-pressure and verdict; depends on doubled_byte_run_length_encoder, rle_stream_checker
module testbench;

  localparam int RANDOM_ITEMS   = 920;
  localparam int STALL_AT       = 250;
  localparam int PAUSE_AT       = 500;
  localparam int CALM_AFTER     = 800;
  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       is_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;

  bit calm;
  bit hold_req;
  int items_sent;
  int idle_cycles;
  int mismatches;
  int backlog;

  always #5 clk = ~clk;

  doubled_byte_run_length_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  rle_stream_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  // offer one word, with an occasional idle burst first, and wait for it to be taken
  task automatic send_word(input logic [7:0] b, input logic l);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_last   <= l;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_run(input logic [7:0] b, input int n, input logic ends_stream);
    for (int i = 0; i < n; i++) begin
      send_word(b, ends_stream && (i == n - 1));
    end
  endtask

  // stream of runs: mostly short, some medium, now and then past the run limit
  task automatic run_stream();
    int runs;
    int n;
    int r;
    logic [7:0] b;
    runs = $urandom_range(1, 8);
    b = 8'($urandom);
    for (int k = 0; k < runs; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) n = 1;
      else if (r < 80) n = $urandom_range(2, 4);
      else if (r < 98) n = $urandom_range(5, 30);
      else n = $urandom_range(250, 260);
      send_run(b, n, k == runs - 1);
      // keeping the same byte merges two runs into one
      r = $urandom_range(0, 5);
      if (r == 0) b = 8'h00;
      else if (r == 1) b = 8'hFF;
      else if (r > 2) b = 8'($urandom);
    end
  endtask

  task automatic noise_stream();
    int len;
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      send_word(8'($urandom), ($urandom_range(0, 7) == 0) || (i == len - 1));
    end
  endtask

  initial begin
    bit stall_done;
    bit pause_done;
    stall_done = 1'b0;
    pause_done = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    is_last   <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // single-byte streams at both extremes
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    // pair closing the stream, no count
    send_run(8'hA5, 2, 1'b1);
    // run broken by a different byte
    send_run(8'h3C, 4, 1'b0);
    send_word(8'hC3, 1'b1);
    // equal last byte inside a run goes out as a literal
    send_run(8'h5A, 3, 1'b1);
    send_run(8'hFF, 2, 1'b0);
    send_run(8'h00, 2, 1'b1);
    // full run, then equal bytes start fresh
    send_run(8'h77, 259, 1'b1);
    // longest count below the limit, then a mismatch
    send_run(8'h81, 256, 1'b0);
    send_word(8'h18, 1'b1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!stall_done && items_sent >= STALL_AT) begin
        hold_req   = 1'b1;
        stall_done = 1'b1;
      end
      if (!pause_done && items_sent >= PAUSE_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0) @(posedge clk);
        pause_done = 1'b1;
      end
      if (items_sent >= CALM_AFTER) calm = 1'b1;
      if ($urandom_range(0, 4) == 0) noise_stream();
      else run_stream();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // no word moving on either channel for too long means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

endmodule
